[sv/segment_rectangle_intersection_macros.svh]
// Assertion macros for the segment and rectangle hit test.
// Used by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef SEGMENT_RECTANGLE_INTERSECTION_MACROS_SVH
`define SEGMENT_RECTANGLE_INTERSECTION_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent holds, consequent must hold in the same cycle.
`define SRI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: label");
// Antecedent holds, consequent must hold in the following cycle.
`define SRI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: label");
`else
`define SRI_ASSERT_SAME(label, ante, cons)
`define SRI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/sri_pkg.sv]
// Shared widths, side codes and pipeline records for the segment hit test.
// No dependencies; compiled first.
package sri_pkg;

    // Coordinate width and derived working widths.
    localparam int CW = 16;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int WW = DW + 2;
    // Number of registers from a side unit's input to its registered result.
    localparam int SIDE_LAT = DW + 3;

    // Side codes.
    localparam logic [1:0] SIDE_LEFT   = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_TOP    = 2'd2;
    localparam logic [1:0] SIDE_BOTTOM = 2'd3;

    // One side test: the segment runs from (a1,b1) to (a2,b2); the side is
    // a == pos, spanning b in [base, base+len].
    typedef struct packed {
        logic signed [CW-1:0] a1;
        logic signed [CW-1:0] b1;
        logic signed [CW-1:0] a2;
        logic signed [CW-1:0] b2;
        logic signed [DW-1:0] pos;
        logic signed [CW-1:0] base;
        logic [CW-2:0]        len;
    } side_in_t;

    // Context carried alongside the divider.
    typedef struct packed {
        logic                 ok;
        logic                 neg;
        logic signed [CW-1:0] b1;
        logic signed [CW-1:0] base;
        logic [CW-2:0]        len;
        logic [DW-1:0]        ud;
    } side_ctx_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] hb;
    } side_res_t;

    // Rectangle data delayed to the output stage.
    typedef struct packed {
        logic signed [CW-1:0] box_x;
        logic signed [CW-1:0] box_y;
        logic [CW-2:0]        box_width;
        logic [CW-2:0]        box_height;
    } box_t;

endpackage

[sv/sri_channels.sv]
// Request and result channel interfaces for the segment hit test.
// Depends on sri_pkg for the field widths.
interface sri_in_if
    import sri_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] seg_start_x;
    logic signed [CW-1:0] seg_start_y;
    logic signed [CW-1:0] seg_end_x;
    logic signed [CW-1:0] seg_end_y;
    logic signed [CW-1:0] box_x;
    logic signed [CW-1:0] box_y;
    logic [CW-2:0]        box_width;
    logic [CW-2:0]        box_height;

    modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                    box_x, box_y, box_width, box_height, input ready);
    modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  box_x, box_y, box_width, box_height, output ready);
endinterface

interface sri_out_if
    import sri_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [1:0]           side_hit;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;

    modport source (output valid, hit, side_hit, hit_x, hit_y, input ready);
    modport sink (input valid, hit, side_hit, hit_x, hit_y, output ready);
endinterface

[sv/sri_side.sv]
// Pipelined test of a segment against one rectangle side, with exact range
// checks and a one-bit-per-stage restoring divider. Depends on sri_pkg.
module sri_side
    import sri_pkg::*;
(
    input  logic      clk,
    input  logic      en,
    input  side_in_t  side_in,
    output side_res_t side_res
);

    // Setup stage signals.
    logic signed [DW:0] a1_w, a2_w, b1_w, b2_w, pos_w;
    logic signed [DW:0] da_w, db_w, t_w, ud_w, tt_w, mdb_w;
    side_ctx_t          ctx0_next;
    side_ctx_t          ctx0_reg;
    logic [DW-1:0]      ut_reg, mdb_reg, ut_next, mdb_next;

    // Divider pipeline.
    side_ctx_t     ctx_reg [0:DW];
    logic [DW-1:0] r_reg   [0:DW];
    logic [DW-1:0] dq_reg  [0:DW];
    logic [PW-1:0] prod;

    // Final stage signals.
    logic signed [WW-1:0] b1_f, mag_f, y_f, lo_f, hi_f, off_f, hb_f;
    logic                 up_f;
    side_ctx_t            ctx_f;
    logic [DW-1:0]        mag, rem;
    side_res_t            res_next;
    side_res_t            res_reg;

    // Differences, sign fix and range of the segment parameter.
    always_comb
    begin
        a1_w  = side_in.a1;
        a2_w  = side_in.a2;
        b1_w  = side_in.b1;
        b2_w  = side_in.b2;
        pos_w = side_in.pos;
        da_w  = a2_w - a1_w;
        db_w  = b2_w - b1_w;
        t_w   = pos_w - a1_w;
        ud_w  = da_w[DW] ? -da_w : da_w;
        tt_w  = da_w[DW] ? -t_w : t_w;
        mdb_w = db_w[DW] ? -db_w : db_w;
        ctx0_next.ok   = (da_w != '0) && (side_in.len != '0) && !tt_w[DW]
                         && (tt_w <= ud_w);
        ctx0_next.neg  = db_w[DW];
        ctx0_next.b1   = side_in.b1;
        ctx0_next.base = side_in.base;
        ctx0_next.len  = side_in.len;
        ctx0_next.ud   = ud_w[DW-1:0];
        ut_next        = tt_w[DW-1:0];
        mdb_next       = mdb_w[DW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx0_reg <= ctx0_next;
            ut_reg   <= ut_next;
            mdb_reg  <= mdb_next;
        end
    end

    // Product of the parameter and the offset span; the high half is below ud.
    assign prod = PW'(ut_reg) * PW'(mdb_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= ctx0_reg;
            r_reg[0]   <= prod[PW-1:DW];
            dq_reg[0]  <= prod[DW-1:0];
        end
    end

    // One quotient bit per stage: shift in a dividend bit, subtract if it fits.
    for (genvar k = 1; k <= DW; k++)
    begin : g_div
        logic [DW:0] trial;
        logic        fits;

        always_comb
        begin
            trial = {r_reg[k-1], dq_reg[k-1][DW-1]};
            fits  = trial >= {1'b0, ctx_reg[k-1].ud};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
                r_reg[k]   <= fits ? DW'(trial - {1'b0, ctx_reg[k-1].ud})
                                   : trial[DW-1:0];
                dq_reg[k]  <= {dq_reg[k-1][DW-2:0], fits};
            end
        end
    end

    // Floor of the crossing point, range check along the side, and rounding.
    always_comb
    begin
        ctx_f = ctx_reg[DW];
        mag   = dq_reg[DW];
        rem   = r_reg[DW];
        b1_f  = ctx_f.b1;
        mag_f = $signed({2'b00, mag});
        lo_f  = ctx_f.base;
        hi_f  = lo_f + $signed({{(WW-CW+1){1'b0}}, ctx_f.len});
        if (!ctx_f.neg)
            y_f = b1_f + mag_f;
        else if (rem == '0)
            y_f = b1_f - mag_f;
        else
            y_f = b1_f - mag_f - WW'(1);
        up_f  = {rem, 1'b0} >= {1'b0, ctx_f.ud};
        off_f = mag_f + $signed({{(WW-1){1'b0}}, up_f});
        hb_f  = ctx_f.neg ? (b1_f - off_f) : (b1_f + off_f);
        res_next.hit = ctx_f.ok && (y_f >= lo_f)
                       && ((y_f < hi_f) || ((y_f == hi_f) && (rem == '0)));
        res_next.hb  = hb_f[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign side_res = res_reg;

endmodule

[sv/segment_rectangle_intersection.sv]
// Segment versus axis-aligned rectangle hit test, top level.
// Takes one request per cycle on seg_in while no result is held, and delivers
// one result per request on hit_out, both valid/ready channels; a request
// moves when valid and ready are high at a rising clock edge.
// Each request holds a segment and a rectangle (corner, width, height) in
// signed Q12.4. Four side units (left, right, top, bottom) run in parallel;
// the first side crossed in that order is reported with the rounded point,
// and a miss reports all zeros.
// A request passes through the side units and then the output register. Throughput is
// one request per cycle unless a result is held; the depth comes from the 17-stage
// restoring divider in each side unit, which yields one quotient bit per stage.
// The whole pipeline, output register included, advances together. When the
// receiver holds ready low while a result is shown, the pipeline freezes and
// seg_in.ready drops, so nothing is lost or repeated; bubbles do not stall.
// Reset clears the valid bits only, leaving the pipeline empty.
// Depends on sri_pkg, sri_channels, sri_side and the assertion macros.
`include "segment_rectangle_intersection_macros.svh"

module segment_rectangle_intersection
    import sri_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sri_in_if.sink      seg_in,
    sri_out_if.source   hit_out
);

    logic                 en;
    side_in_t             sin [0:3];
    side_res_t            sres [0:3];
    logic [SIDE_LAT-1:0]  vld_reg;
    box_t                 box_reg [0:SIDE_LAT-1];
    box_t                 box_in;
    box_t                 box_f;
    logic signed [DW-1:0] right_w, bottom_w;

    logic                 out_vld_reg;
    logic                 hit_reg, hit_next;
    logic [1:0]           side_reg, side_next;
    logic signed [CW-1:0] hx_reg, hy_reg, hx_next, hy_next;

    // The whole pipeline moves unless a shown result is held.
    assign en           = !(out_vld_reg && !hit_out.ready);
    assign seg_in.ready = en;

    // Side requests: left and right use x as the crossing axis, top and bottom y.
    always_comb
    begin
        right_w  = DW'(seg_in.box_x) + $signed({2'b00, seg_in.box_width});
        bottom_w = DW'(seg_in.box_y) + $signed({2'b00, seg_in.box_height});

        sin[0] = '{a1: seg_in.seg_start_x, b1: seg_in.seg_start_y,
                   a2: seg_in.seg_end_x, b2: seg_in.seg_end_y,
                   pos: DW'(seg_in.box_x), base: seg_in.box_y,
                   len: seg_in.box_height};
        sin[1] = sin[0];
        sin[1].pos = right_w;
        sin[2] = '{a1: seg_in.seg_start_y, b1: seg_in.seg_start_x,
                   a2: seg_in.seg_end_y, b2: seg_in.seg_end_x,
                   pos: DW'(seg_in.box_y), base: seg_in.box_x,
                   len: seg_in.box_width};
        sin[3] = sin[2];
        sin[3].pos = bottom_w;

        box_in = '{box_x: seg_in.box_x, box_y: seg_in.box_y,
                   box_width: seg_in.box_width, box_height: seg_in.box_height};
    end

    for (genvar s = 0; s < 4; s++)
    begin : g_side
        sri_side u_side (
            .clk      (clk),
            .en       (en),
            .side_in  (sin[s]),
            .side_res (sres[s])
        );
    end

    // Valid bits travel beside the side units.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[SIDE_LAT-2:0], seg_in.valid};
    end

    // Rectangle data delayed to line up with the side results.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            box_reg[0] <= box_in;
            for (int i = 1; i < SIDE_LAT; i++)
                box_reg[i] <= box_reg[i-1];
        end
    end

    // Fixed-order selection of the first side crossed.
    always_comb
    begin
        logic signed [DW-1:0] edge_w;
        box_f     = box_reg[SIDE_LAT-1];
        hit_next  = 1'b1;
        side_next = SIDE_LEFT;
        hx_next   = '0;
        hy_next   = '0;
        edge_w    = '0;
        if (sres[0].hit)
        begin
            side_next = SIDE_LEFT;
            hx_next   = box_f.box_x;
            hy_next   = sres[0].hb;
        end
        else if (sres[1].hit)
        begin
            side_next = SIDE_RIGHT;
            edge_w    = DW'(box_f.box_x) + $signed({2'b00, box_f.box_width});
            hx_next   = edge_w[CW-1:0];
            hy_next   = sres[1].hb;
        end
        else if (sres[2].hit)
        begin
            side_next = SIDE_TOP;
            hx_next   = sres[2].hb;
            hy_next   = box_f.box_y;
        end
        else if (sres[3].hit)
        begin
            side_next = SIDE_BOTTOM;
            edge_w    = DW'(box_f.box_y) + $signed({2'b00, box_f.box_height});
            hx_next   = sres[3].hb;
            hy_next   = edge_w[CW-1:0];
        end
        else
        begin
            hit_next = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vld_reg[SIDE_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit_next;
            side_reg <= side_next;
            hx_reg   <= hx_next;
            hy_reg   <= hy_next;
        end
    end

    assign hit_out.valid    = out_vld_reg;
    assign hit_out.hit      = hit_reg;
    assign hit_out.side_hit = side_reg;
    assign hit_out.hit_x    = hx_reg;
    assign hit_out.hit_y    = hy_reg;

    // A miss reports a zero point and the left code.
    `SRI_ASSERT_SAME(a_miss_zero, out_vld_reg && !hit_reg, side_reg == SIDE_LEFT && hx_reg == '0 && hy_reg == '0)
    // A held result blocks new requests.
    `SRI_ASSERT_SAME(a_stall_blocks, out_vld_reg && !hit_out.ready, !seg_in.ready)
    // A frozen pipeline keeps its valid bits.
    `SRI_ASSERT_NEXT(a_freeze_keeps, !en, $stable(vld_reg) && out_vld_reg)

endmodule

[tb/sri_tb_channels.sv]
// Request and report types that the testbench builds and predicts.
// Depends on sri_pkg; the channel interfaces come from the RTL's sri_channels.
`timescale 1ns / 100ps
package sri_tb_types;
    import sri_pkg::*;
    // One segment and rectangle request as the testbench builds it.
    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic [CW-2:0]        bw;
        logic [CW-2:0]        bh;
    } hit_req_t;
    // Expected hit report.
    typedef struct packed {
        logic                 hit;
        logic [1:0]           side;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } hit_rpt_t;
endpackage

[tb/testbench.sv]
// Testbench for the segment and rectangle hit test.
// Depends on sri_pkg, sri_channels, sri_tb_types and the block's RTL; drives
// requests, predicts each hit report and compares it with the block's result.
`timescale 1ns / 100ps

module testbench;
    import sri_pkg::*;
    import sri_tb_types::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int   errors;
    int   cycles;
    int   idle_pct_in;
    int   idle_pct_out;
    int   hold_off;
    bit   done;
    hit_rpt_t expected_reports[$];

    sri_in_if  seg_in ();
    sri_out_if hit_out ();

    segment_rectangle_intersection u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .seg_in  (seg_in.sink),
        .hit_out (hit_out.source)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Crossing test of one side at a == pos spanning b in [base, base+len].
    function automatic bit cross_one(longint a1, longint b1, longint a2, longint b2,
                                     longint pos, longint base, longint len,
                                     output longint hb);
        longint da, db, t, mdb, q, r, pr, fl, rem, mag, f, y, up;
        hb = 0;
        da = a2 - a1;
        db = b2 - b1;
        t = pos - a1;
        if (da == 0 || len == 0)
            return 0;
        if (da < 0)
        begin
            da = -da;
            t = -t;
        end
        if (t < 0 || t > da)
            return 0;
        mdb = (db < 0) ? -db : db;
        q = mdb / da;
        r = mdb % da;
        pr = t * r;
        fl = pr / da;
        rem = pr % da;
        mag = t * q + fl;
        if (db >= 0)
        begin
            y = b1 + mag;
            f = rem;
        end
        else if (rem == 0)
        begin
            y = b1 - mag;
            f = 0;
        end
        else
        begin
            y = b1 - mag - 1;
            f = da - rem;
        end
        if (y < base)
            return 0;
        if (y > base + len || (y == base + len && f != 0))
            return 0;
        up = (2 * rem >= da) ? 1 : 0;
        hb = (db >= 0) ? b1 + mag + up : b1 - (mag + up);
        return 1;
    endfunction

    // First side crossed in the order left, right, top, bottom.
    function automatic hit_rpt_t predict_hit(hit_req_t rq);
        hit_rpt_t rp;
        longint x1, y1, x2, y2, rx, ry, rw, rh, v;
        x1 = rq.sx; y1 = rq.sy; x2 = rq.ex; y2 = rq.ey;
        rx = rq.bx; ry = rq.by; rw = rq.bw; rh = rq.bh;
        rp = '0;
        if (cross_one(x1, y1, x2, y2, rx, ry, rh, v))
        begin
            rp.hit = 1; rp.side = SIDE_LEFT; rp.x = rx[CW-1:0]; rp.y = v[CW-1:0];
        end
        else if (cross_one(x1, y1, x2, y2, rx + rw, ry, rh, v))
        begin
            rp.hit = 1; rp.side = SIDE_RIGHT; rp.x = CW'(rx + rw); rp.y = v[CW-1:0];
        end
        else if (cross_one(y1, x1, y2, x2, ry, rx, rw, v))
        begin
            rp.hit = 1; rp.side = SIDE_TOP; rp.x = v[CW-1:0]; rp.y = ry[CW-1:0];
        end
        else if (cross_one(y1, x1, y2, x2, ry + rh, rx, rw, v))
        begin
            rp.hit = 1; rp.side = SIDE_BOTTOM; rp.x = v[CW-1:0]; rp.y = CW'(ry + rh);
        end
        return rp;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Sends one request, idling at random, and queues its expected report.
    // Valid stays high after the request so that the next one can follow at
    // once; it drops only while idling or at the end of the run.
    task automatic send_request(hit_req_t rq);
        while ($urandom_range(99) < idle_pct_in)
        begin
            seg_in.valid <= 1'b0;
            @(negedge clk);
        end
        seg_in.valid       <= 1'b1;
        seg_in.seg_start_x <= rq.sx;
        seg_in.seg_start_y <= rq.sy;
        seg_in.seg_end_x   <= rq.ex;
        seg_in.seg_end_y   <= rq.ey;
        seg_in.box_x       <= rq.bx;
        seg_in.box_y       <= rq.by;
        seg_in.box_width   <= rq.bw;
        seg_in.box_height  <= rq.bh;
        do
            @(posedge clk);
        while (!seg_in.ready);
        expected_reports.push_back(predict_hit(rq));
        @(negedge clk);
    endtask

    // Result ready: random idling, or a long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            hit_out.ready <= 1'b0;
        end
        else
            hit_out.ready <= ($urandom_range(99) >= idle_pct_out);
    end

    // Result checker.
    always @(posedge clk)
    begin
        hit_rpt_t want;
        if (rst_n && hit_out.valid && hit_out.ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("mismatch: result with no request outstanding");
                errors++;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (hit_out.hit !== want.hit)
                    report_mismatch("hit", hit_out.hit, want.hit);
                if (hit_out.side_hit !== want.side)
                    report_mismatch("side_hit", hit_out.side_hit, want.side);
                if (hit_out.hit_x !== want.x)
                    report_mismatch("hit_x", hit_out.hit_x, want.x);
                if (hit_out.hit_y !== want.y)
                    report_mismatch("hit_y", hit_out.hit_y, want.y);
            end
        end
    end

    function automatic hit_req_t make_req(int sx, int sy, int ex, int ey,
                                          int bx, int by, int bw, int bh);
        hit_req_t rq;
        rq.sx = CW'(sx); rq.sy = CW'(sy); rq.ex = CW'(ex); rq.ey = CW'(ey);
        rq.bx = CW'(bx); rq.by = CW'(by); rq.bw = (CW-1)'(bw); rq.bh = (CW-1)'(bh);
        return rq;
    endfunction

    // Sides, misses, parallel and degenerate segments, field extremes.
    task automatic test_directed();
        send_request(make_req(-100, 50, 100, 50, 0, 0, 160, 160));
        send_request(make_req(100, 50, 300, 50, 0, 0, 160, 160));
        send_request(make_req(50, -100, 50, 100, 0, 0, 160, 160));
        send_request(make_req(50, 100, 50, 300, 0, 0, 160, 160));
        send_request(make_req(10, 10, 20, 20, 0, 0, 160, 160));
        send_request(make_req(0, -50, 0, 300, 0, 0, 160, 160));
        send_request(make_req(5, 5, 5, 5, 0, 0, 160, 160));
        send_request(make_req(-100, 50, 100, 50, 0, 0, 0, 160));
        send_request(make_req(-100, 50, 100, 50, 0, 0, 160, 0));
        send_request(make_req(-100, 0, 100, 3, 0, 0, 16, 16));
        send_request(make_req(-100, 0, 100, -3, 0, 0, 16, 16));
        send_request(make_req(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
        send_request(make_req(32767, -32768, -32768, 32767, 0, 0, 32767, 32767));
        send_request(make_req(-32768, 32767, 32767, -32768, 32767, 32767, 32767, 32767));
        send_request(make_req(-10, -10, 10, 10, 0, 0, 0, 0));
        send_request(make_req(-7, 0, 7, 1, 0, 0, 5, 5));
        send_request(make_req(32767, 32767, -32768, -32768, -32768, -32768, 0, 32767));
        send_request(make_req(-50, 20, 50, 20, -32768, 0, 32767, 32767));
    endtask

    function automatic hit_req_t rand_req();
        hit_req_t rq;
        int span;
        rq = hit_req_t'({$urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(99) < 75)
        begin
            // Segment near a modest box so that most requests hit something.
            span = (1 << $urandom_range(14, 4));
            rq.bw = (CW-1)'($urandom_range(span));
            rq.bh = (CW-1)'($urandom_range(span));
            rq.bx = $signed(16'($urandom_range(4 * span))) - 16'(2 * span);
            rq.by = $signed(16'($urandom_range(4 * span))) - 16'(2 * span);
            rq.sx = rq.bx + $signed(16'($urandom_range(3 * span))) - 16'(span);
            rq.sy = rq.by + $signed(16'($urandom_range(3 * span))) - 16'(span);
            rq.ex = rq.bx + $signed(16'($urandom_range(3 * span))) - 16'(span);
            rq.ey = rq.by + $signed(16'($urandom_range(3 * span))) - 16'(span);
            if ($urandom_range(9) == 0)
                rq.ex = rq.sx;
        end
        return rq;
    endfunction

    // Random requests with idling on both sides.
    task automatic test_random(int count, int in_pct, int out_pct);
        idle_pct_in = in_pct;
        idle_pct_out = out_pct;
        repeat (count)
            send_request(rand_req());
    endtask

    // Receiver holds off long enough that the pipeline fills and stalls input.
    task automatic test_backpressure();
        idle_pct_in = 0;
        hold_off = 80;
        repeat (60)
            send_request(rand_req());
        idle_pct_out = 34;
    endtask

    initial
    begin
        int waited;
        errors = 0;
        cycles = 0;
        hold_off = 0;
        idle_pct_in = 34;
        idle_pct_out = 34;
        rst_n = 1'b0;
        seg_in.valid = 1'b0;
        seg_in.seg_start_x = '0;
        seg_in.seg_start_y = '0;
        seg_in.seg_end_x = '0;
        seg_in.seg_end_y = '0;
        seg_in.box_x = '0;
        seg_in.box_y = '0;
        seg_in.box_width = '0;
        seg_in.box_height = '0;
        hit_out.ready = 1'b0;
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(400, 34, 34);
        test_backpressure();
        test_random(250, 0, 0);
        test_random(300, 34, 34);
        seg_in.valid <= 1'b0;
        waited = 0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        while (waited < 3 * (SIDE_LAT + 1))
        begin
            @(posedge clk);
            waited++;
        end
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

[sim.f]
+incdir+sv
sv/sri_pkg.sv
sv/sri_channels.sv
sv/sri_side.sv
sv/segment_rectangle_intersection.sv
tb/sri_tb_channels.sv
tb/testbench.sv
